/* src/bfl_pkg.sv */
// Shared types and constants for the bitmap font text layout block.
package bfl_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ScaleW  = 12;
  localparam int unsigned FracW   = 8;
  localparam int unsigned DivStep = CodeW;
  localparam int unsigned CntW    = $clog2(DivStep);

  localparam logic [CodeW-1:0] CodeSpace   = 8'd32;
  localparam logic [CodeW-1:0] CodeNewline = 8'd10;

  localparam logic [7:0] RstCharWidth  = 8'd8;
  localparam logic [7:0] RstCharHeight = 8'd8;
  localparam logic [7:0] RstNumCols    = 8'd16;
  localparam logic [7:0] RstStartChar  = 8'd32;

  typedef enum logic [1:0] {
    CFG_CHAR_WIDTH  = 2'd0,
    CFG_CHAR_HEIGHT = 2'd1,
    CFG_NUM_COLS    = 2'd2,
    CFG_START_CHAR  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SPACE   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_GLYPH   = 2'd2,
    KIND_BELOW   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* src/bitmap_font_text_layout.sv */
// Top level of the bitmap font text layout block.
//
// Input stream: one character request per transfer. s_axis_tuser is the
// first-of-string flag; it latches origin_x/origin_y as the pen and line
// start before the character is handled.
// Output stream: one result per request, kind in m_axis_tuser, destination
// pen position and source cell rectangle in m_axis_tdata.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 char_width, 1 char_height, 2 num_cols, 3 start_char); write only idle.
// Timing: the accepting cycle loads a request, then the shared restoring
// divider yields the cell row and column (one quotient bit a cycle), then
// come the product state and the result state. A request is accepted only
// when the controller is back in idle after the last one: s_axis_tready is
// high only while the controller is idle.
// The output register holds a finished result while the next request is
// accepted and divided; if it is still occupied at the result cycle the
// controller waits there until m_axis_tready frees it.
// Reset clears pen, line start and the output valid flag and restores the
// default font geometry (8x8 cells, 16 columns, first code 32).
module bitmap_font_text_layout
  import bfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ch, origin_x, origin_y, scale, zero pad
  input  logic [55:0] s_axis_tdata,
  // first
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dest_x, dest_y, src_left, src_top, src_right, src_bottom
  output logic [95:0] m_axis_tdata,
  // kind
  output logic [1:0]  m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  bfl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  bfl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* src/bfl_ctrl.sv */
// Sequencing state machine for the text layout block.
module bfl_ctrl
  import bfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_DIV;
      ST_DIV:  if (cnt_q == CntW'(DivStep - 1)) state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN:  if (sts_i.out_free) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      ST_DIV:  cmd_o.step = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_FIN:  cmd_o.fin  = sts_i.out_free;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DIV) && (cnt_q == '0))
    else $error("division did not start after a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == CntW'(DivStep - 1)) |=> state_q == ST_MUL)
    else $error("division ran past its step count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.mul, cmd_o.fin}))
    else $error("more than one datapath command at once");

endmodule

/* src/bfl_dp.sv */
// Datapath: config registers, pen state, cell divider, products and result register.
module bfl_dp
  import bfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  logic [7:0] char_width_q, char_height_q, num_cols_q, start_char_q;
  logic [PosW-1:0] pen_x_q, pen_y_q, line_x_q;

  logic [CodeW-1:0]  ch_q;
  logic [ScaleW-1:0] scale_q;
  logic              below_q;
  logic [7:0]        rem_q, quot_q;
  logic [PosW-1:0]   adv_q, left_q, top_q;

  logic              out_valid_q;
  logic [95:0]       out_data_q;
  kind_e             out_kind_q;

  logic [CodeW-1:0]  in_ch;
  logic [PosW-1:0]   in_ox, in_oy;
  logic [ScaleW-1:0] in_scale;
  logic [7:0]        divisor;
  logic [8:0]        trial;
  logic              fits;
  logic [ScaleW+7:0] adv_prod;

  logic [PosW-1:0]   pen_adv, new_pen_x, new_pen_y;
  logic [PosW-1:0]   dest_x, dest_y, src_l, src_t, src_r, src_b;
  kind_e             kind;

  assign in_ch    = s_axis_tdata[7:0];
  assign in_ox    = s_axis_tdata[23:8];
  assign in_oy    = s_axis_tdata[39:24];
  assign in_scale = s_axis_tdata[51:40];

  assign divisor  = (num_cols_q == 8'd0) ? 8'd1 : num_cols_q;
  assign trial    = {rem_q, quot_q[7]};
  assign fits     = trial >= {1'b0, divisor};
  assign adv_prod = (ScaleW+8)'(char_width_q) * (ScaleW+8)'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_width_q  <= RstCharWidth;
      char_height_q <= RstCharHeight;
      num_cols_q    <= RstNumCols;
      start_char_q  <= RstStartChar;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHAR_WIDTH:  char_width_q  <= cfg_data_i;
        CFG_CHAR_HEIGHT: char_height_q <= cfg_data_i;
        CFG_NUM_COLS:    num_cols_q    <= cfg_data_i;
        CFG_START_CHAR:  start_char_q  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q    <= in_ch;
      scale_q <= in_scale;
      below_q <= in_ch < start_char_q;
      rem_q   <= '0;
      quot_q  <= in_ch - start_char_q;
    end else if (cmd_i.step) begin
      rem_q  <= fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      quot_q <= {quot_q[6:0], fits};
    end
    if (cmd_i.mul) begin
      adv_q  <= PosW'(adv_prod[ScaleW+7:FracW]);
      left_q <= PosW'(rem_q) * PosW'(char_width_q);
      top_q  <= PosW'(quot_q) * PosW'(char_height_q);
    end
  end

  assign pen_adv = pen_x_q + adv_q;

  always_comb begin
    new_pen_x = pen_adv;
    new_pen_y = pen_y_q;
    dest_x    = pen_x_q;
    dest_y    = pen_y_q;
    src_l     = '0;
    src_t     = '0;
    src_r     = '0;
    src_b     = '0;
    if (ch_q == CodeSpace) begin
      kind   = KIND_SPACE;
      dest_x = pen_adv;
    end else if (ch_q == CodeNewline) begin
      kind      = KIND_NEWLINE;
      new_pen_x = line_x_q;
      new_pen_y = pen_y_q + PosW'(char_height_q);
      dest_x    = line_x_q;
      dest_y    = new_pen_y;
    end else if (below_q) begin
      kind = KIND_BELOW;
    end else begin
      kind  = KIND_GLYPH;
      src_l = left_q;
      src_t = top_q;
      src_r = left_q + PosW'(char_width_q);
      src_b = top_q + PosW'(char_height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      line_x_q <= '0;
    end else if (cmd_i.load && s_axis_tuser) begin
      pen_x_q  <= in_ox;
      pen_y_q  <= in_oy;
      line_x_q <= in_ox;
    end else if (cmd_i.fin) begin
      pen_x_q <= new_pen_x;
      pen_y_q <= new_pen_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_q <= {src_b, src_r, src_t, src_l, dest_y, dest_x};
      out_kind_q <= kind;
    end
  end

  assign sts_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid  = out_valid_q;
  assign m_axis_tdata   = out_data_q;
  assign m_axis_tuser   = out_kind_q;

endmodule
